[design/ftc_pkg.sv]
package ftc_pkg;

  localparam int RANK_W   = 10;
  localparam int COUNT_W  = 28;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

endpackage

[design/forward_triangle_counter.sv]
// Channel | Direction | Payload
// s_*     | in        | tdata: node_rank [9:0], neighbor_rank [19:10], zeros [23:20];
//         |           | tuser: has_edge; tlast: last_of_graph
// m_*     | out       | tdata: triangle_count [27:0], zeros [31:28]; tuser: list_overflow
//
// A forward entry passes through the LEN, MERGE and APPEND states; the merge loop does
// one compare per cycle against the two read ports of the in-list store, with at most as
// many compares as both in-list lengths together, so up to 2*MAX_IN_DEGREE. Any other
// item stays in the idle state unless it ends the graph. The last item leads to EMIT to
// load the result, then a length clearing pass over min(MAX_NODES, 1024) entries follows.
// The same clearing pass runs after reset; no input is taken while it runs.
// A result waiting on m_tready stalls only the next end of graph, not the edges before it.
module forward_triangle_counter
  import ftc_pkg::*;
#(
  parameter int MAX_NODES     = 1024,
  parameter int MAX_IN_DEGREE = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // node_rank, neighbor_rank
  input  logic                s_tuser,   // has_edge
  input  logic                s_tlast,   // last_of_graph
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // triangle_count
  output logic                m_tuser    // list_overflow
);

  localparam int NODES  = (MAX_NODES < (1 << RANK_W)) ? MAX_NODES : (1 << RANK_W);
  localparam int NODE_W = $clog2(NODES);
  localparam int DEG_W  = $clog2(MAX_IN_DEGREE);
  localparam int LEN_W  = $clog2(MAX_IN_DEGREE + 1);
  localparam int ADDR_W = NODE_W + DEG_W;
  localparam int DEPTH  = NODES << DEG_W;

  localparam logic [RANK_W:0]  NODES_L   = (RANK_W + 1)'(NODES);
  localparam logic [LEN_W-1:0] LEN_FULL  = LEN_W'(MAX_IN_DEGREE);
  localparam logic [NODE_W-1:0] CLR_LAST = NODE_W'(NODES - 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_LEN    = 3'd2;
  localparam logic [2:0] ST_MERGE  = 3'd3;
  localparam logic [2:0] ST_APPEND = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0]         state;
  logic [NODE_W-1:0]  node_a;
  logic [NODE_W-1:0]  node_b;
  logic               last_q;
  logic [NODE_W-1:0]  clr;
  logic [LEN_W-1:0]   x;
  logic [LEN_W-1:0]   y;
  logic [LEN_W-1:0]   x_next;
  logic [LEN_W-1:0]   y_next;
  logic [COUNT_W-1:0] count;
  logic               overflow;

  logic [RANK_W-1:0]  store_mem [DEPTH];
  logic [RANK_W-1:0]  store_qa;
  logic [RANK_W-1:0]  store_qb;
  logic               store_we;
  logic [ADDR_W-1:0]  store_waddr;

  logic [LEN_W-1:0]   len_mem [NODES];
  logic [LEN_W-1:0]   len_qa;
  logic [LEN_W-1:0]   len_qb;
  logic               len_we;
  logic [NODE_W-1:0]  len_waddr;
  logic [LEN_W-1:0]   len_wdata;

  logic [RANK_W-1:0]  in_i;
  logic [RANK_W-1:0]  in_j;
  logic               in_fwd;
  logic               accept;
  logic               run;
  logic               hit;
  logic               list_full;
  logic               emit_load;
  logic [COUNT_W-1:0] count_inc;

  assign in_i   = s_tdata[RANK_W-1:0];
  assign in_j   = s_tdata[2*RANK_W-1:RANK_W];
  assign in_fwd = s_tuser && ({1'b0, in_i} < NODES_L) && ({1'b0, in_j} < NODES_L)
                  && (in_j > in_i);

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign run       = (x < len_qa) && (y < len_qb);
  assign list_full = (len_qb >= LEN_FULL);
  assign emit_load = (state == ST_EMIT) && (!m_tvalid || m_tready);
  assign count_inc = (count == COUNT_MAX) ? count : count + 1'b1;

  // The store is read at the next merge position, so the registered data always
  // matches the current x and y.
  always_comb begin
    x_next = '0;
    y_next = '0;
    hit    = 1'b0;
    if (state == ST_MERGE) begin
      x_next = x;
      y_next = y;
      if (run) begin
        if (store_qa < store_qb) begin
          x_next = x + 1'b1;
        end else if (store_qa > store_qb) begin
          y_next = y + 1'b1;
        end else begin
          x_next = x + 1'b1;
          y_next = y + 1'b1;
          hit    = 1'b1;
        end
      end
    end
  end

  assign store_we    = (state == ST_APPEND) && !list_full;
  assign store_waddr = {node_b, len_qb[DEG_W-1:0]};

  always_comb begin
    len_we    = 1'b0;
    len_waddr = node_b;
    len_wdata = len_qb + 1'b1;
    if (state == ST_CLEAR) begin
      len_we    = 1'b1;
      len_waddr = clr;
      len_wdata = '0;
    end else if (store_we) begin
      len_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= {{(RANK_W - NODE_W){1'b0}}, node_a};
    end
    store_qa <= store_mem[{node_a, x_next[DEG_W-1:0]}];
    store_qb <= store_mem[{node_b, y_next[DEG_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    len_qa <= len_mem[node_a];
    len_qb <= len_mem[node_b];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      node_a <= in_i[NODE_W-1:0];
      node_b <= in_j[NODE_W-1:0];
      last_q <= s_tlast;
    end
    if (emit_load) begin
      m_tdata <= {{(M_DATA_W - COUNT_W){1'b0}}, count};
      m_tuser <= overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr      <= '0;
      x        <= '0;
      y        <= '0;
      count    <= '0;
      overflow <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      x <= x_next;
      y <= y_next;
      if (hit) begin
        count <= count_inc;
      end
      if (m_tvalid && m_tready && !emit_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == CLR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (in_fwd) begin
              state <= ST_LEN;
            end else if (s_tlast) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_LEN: begin
          state <= ST_MERGE;
        end
        ST_MERGE: begin
          if (!run) begin
            state <= ST_APPEND;
          end
        end
        ST_APPEND: begin
          if (list_full) begin
            overflow <= 1'b1;
          end
          state <= last_q ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (emit_load) begin
            m_tvalid <= 1'b1;
            count    <= '0;
            overflow <= 1'b0;
            clr      <= '0;
            state    <= ST_CLEAR;
          end
        end
        default: begin
          state <= ST_CLEAR;
          clr   <= '0;
        end
      endcase
    end
  end

  a_merge_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE) |-> (x <= len_qa) && (y <= len_qb))
    else $error("merge position ran past an in-list length");

  a_len_limit: assert property (@(posedge clk) disable iff (rst)
    len_we |-> (len_wdata <= LEN_FULL))
    else $error("in-list length written above capacity");

  a_store_write: assert property (@(posedge clk) disable iff (rst)
    store_we |-> (state == ST_APPEND) && (len_qb < LEN_FULL))
    else $error("in-list store written outside an append");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit_load |=> m_tvalid && (count == '0) && !overflow && (state == ST_CLEAR))
    else $error("end of graph did not hand off the result and clear the count");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE || state == ST_CLEAR) |-> !s_tready)
    else $error("input taken while a merge or clearing pass is running");

endmodule

[tb/sv/forward_triangle_counter_tb.sv]
module forward_triangle_counter_tb;
  import ftc_pkg::*;

  localparam int NODES        = 1024;
  localparam int IN_DEGREE    = 64;
  localparam int TARGET_ITEMS = 1600;
  localparam int DRAIN_CYCLES = 1100;
  localparam int CYCLE_LIMIT  = 10000000;

  typedef struct {
    bit              has_edge;
    bit [RANK_W-1:0] src;
    bit [RANK_W-1:0] dst;
    bit              last;
  } adj_entry_t;

  // Mirrors the in-lists of one graph and queues the count expected at its end.
  class triangle_scoreboard;
    typedef struct packed {
      logic [COUNT_W-1:0] triangle_count;
      logic               list_overflow;
    } graph_tally_t;

    bit [RANK_W-1:0] in_list [NODES][IN_DEGREE];
    int unsigned     list_len [NODES];
    bit [COUNT_W-1:0] count_acc;
    bit              overflow_acc;
    graph_tally_t    tally_q[$];
    int unsigned     errors;

    function new();
      errors = 0;
      clear_graph();
    endfunction

    function void clear_graph();
      foreach (list_len[v]) list_len[v] = 0;
      count_acc = '0;
      overflow_acc = 1'b0;
    endfunction

    // Step-by-step merge; it is applied as is even when a list is unsorted.
    function int unsigned common_entries(int unsigned a, int unsigned b);
      int unsigned x, y, hits;
      x = 0;
      y = 0;
      hits = 0;
      while (x < list_len[a] && y < list_len[b]) begin
        if (in_list[a][x] < in_list[b][y]) begin
          x++;
        end else if (in_list[a][x] > in_list[b][y]) begin
          y++;
        end else begin
          hits++;
          x++;
          y++;
        end
      end
      return hits;
    endfunction

    function void note_input(bit has_edge, bit [RANK_W-1:0] src, bit [RANK_W-1:0] dst,
                             bit last);
      int unsigned  hits, total;
      graph_tally_t done;
      if (has_edge && dst > src && src < NODES && dst < NODES) begin
        hits = common_entries(src, dst);
        total = count_acc + hits;
        if (total > COUNT_MAX) count_acc = COUNT_MAX;
        else count_acc = total[COUNT_W-1:0];
        if (list_len[dst] >= IN_DEGREE) begin
          overflow_acc = 1'b1;
        end else begin
          in_list[dst][list_len[dst]] = src;
          list_len[dst]++;
        end
      end
      if (last) begin
        done.triangle_count = count_acc;
        done.list_overflow  = overflow_acc;
        tally_q.insert(tally_q.size(), done);
        clear_graph();
      end
    endfunction

    function void check_result(logic [M_DATA_W-1:0] data, logic overflow);
      graph_tally_t want;
      if (tally_q.size() == 0) begin
        $error("unexpected result transaction: triangle_count %0d list_overflow %0b",
               data[COUNT_W-1:0], overflow);
        errors++;
        return;
      end
      want = tally_q.pop_front();
      if (data[COUNT_W-1:0] !== want.triangle_count) begin
        $error("triangle_count: expected %0d, actual %0d", want.triangle_count,
               data[COUNT_W-1:0]);
        errors++;
      end
      if (overflow !== want.list_overflow) begin
        $error("list_overflow: expected %0b, actual %0b", want.list_overflow, overflow);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return tally_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;   // node_rank, neighbor_rank
  logic                s_tuser = 1'b0; // has_edge
  logic                s_tlast = 1'b0; // last_of_graph
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;        // triangle_count
  logic                m_tuser;        // list_overflow

  triangle_scoreboard sb = new();
  bit                 calm_phase = 1'b0;
  int unsigned        counted_items = 0;
  int unsigned        cycle_count = 0;

  always #4 clk = ~clk;

  forward_triangle_counter #(
    .MAX_NODES    (NODES),
    .MAX_IN_DEGREE(IN_DEGREE)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm_phase || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void pick_ranks(input int unsigned n, input int unsigned lo,
                                     input int unsigned hi, ref bit [RANK_W-1:0] ranks[$]);
    bit          taken [NODES];
    int unsigned r;
    ranks.delete();
    while (ranks.size() < n) begin
      r = $urandom_range(lo, hi);
      if (!taken[r]) begin
        taken[r] = 1'b1;
        ranks.insert(ranks.size(), r[RANK_W-1:0]);
      end
    end
    ranks.sort();
  endfunction

  function automatic adj_entry_t random_entry(bit last);
    adj_entry_t e;
    e.has_edge = 1'($urandom_range(0, 1));
    e.src = RANK_W'($urandom_range(0, NODES - 1));
    e.dst = RANK_W'($urandom_range(0, NODES - 1));
    e.last = last;
    return e;
  endfunction

  task automatic send_item(input bit has_edge, input bit [RANK_W-1:0] src,
                           input bit [RANK_W-1:0] dst, input bit last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(S_DATA_W - 2 * RANK_W){1'b0}}, dst, src};
    s_tuser <= has_edge;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(has_edge, src, dst, last);
    counted_items++;
  endtask

  task automatic send_sequence(input adj_entry_t seq[$]);
    foreach (seq[k]) send_item(seq[k].has_edge, seq[k].src, seq[k].dst, seq[k].last);
  endtask

  // Random undirected graph, entries grouped by ascending source rank, both directions.
  task automatic dense_graph();
    bit [RANK_W-1:0] ranks[$];
    bit [RANK_W-1:0] nbrs[$];
    adj_entry_t      seq[$];
    bit              linked [16][16];
    int unsigned     n, density, lo, hi;
    n = $urandom_range(3, 14);
    density = $urandom_range(15, 95);
    lo = $urandom_range(0, 960);
    hi = $urandom_range(0, 1) ? lo + 63 : NODES - 1;
    pick_ranks(n, lo, hi, ranks);
    for (int u = 0; u < n; u++) begin
      for (int v = 0; v < u; v++) begin
        linked[u][v] = ($urandom_range(0, 99) < density);
        linked[v][u] = linked[u][v];
      end
    end
    for (int u = 0; u < n; u++) begin
      nbrs.delete();
      for (int v = 0; v < n; v++) begin
        if (linked[u][v]) nbrs.insert(nbrs.size(), ranks[v]);
      end
      nbrs.shuffle();
      foreach (nbrs[k]) seq.insert(seq.size(), '{1'b1, ranks[u], nbrs[k], 1'b0});
      if ($urandom_range(0, 19) == 0) seq.insert(seq.size(), random_entry(1'b0));
    end
    if (seq.size() == 0 || $urandom_range(0, 2) == 0) begin
      seq.insert(seq.size(), '{1'b0, ranks[0], ranks[n-1], 1'b1});
    end else begin
      seq[seq.size()-1].last = 1'b1;
    end
    send_sequence(seq);
  endtask

  // A hub with a fan of lower ranks around the in-list capacity; neighboring fan
  // vertices are linked so that each of them closes a triangle with the hub.
  task automatic hub_graph(input int unsigned fan);
    bit [RANK_W-1:0] ranks[$];
    int unsigned     hub;
    adj_entry_t      seq[$];
    hub = $urandom_range(900, NODES - 1);
    pick_ranks(fan, 0, hub - 1, ranks);
    foreach (ranks[k]) begin
      if (k > 0) seq.insert(seq.size(), '{1'b1, ranks[k], ranks[k-1], 1'b0});
      if (k + 1 < fan) seq.insert(seq.size(), '{1'b1, ranks[k], ranks[k+1], 1'b0});
      seq.insert(seq.size(), '{1'b1, ranks[k], hub[RANK_W-1:0], 1'b0});
    end
    seq.insert(seq.size(), '{1'b1, hub[RANK_W-1:0], ranks[0], 1'b1});
    send_sequence(seq);
  endtask

  task automatic noise_burst();
    adj_entry_t  seq[$];
    int unsigned len;
    len = $urandom_range(3, 20);
    repeat (len) seq.insert(seq.size(), random_entry($urandom_range(0, 9) == 0));
    seq.insert(seq.size(), random_entry(1'b1));
    send_sequence(seq);
  endtask

  initial begin : stimulus
    int unsigned pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty graph: a bare end marker alone.
    send_item(1'b0, 10'd0, 10'd0, 1'b1);
    // One triangle at the lowest ranks, backward entries included.
    send_item(1'b1, 10'd0, 10'd1, 1'b0);
    send_item(1'b1, 10'd0, 10'd2, 1'b0);
    send_item(1'b1, 10'd1, 10'd0, 1'b0);
    send_item(1'b1, 10'd1, 10'd2, 1'b0);
    send_item(1'b1, 10'd2, 10'd0, 1'b0);
    send_item(1'b1, 10'd2, 10'd1, 1'b1);
    // Highest ranks, a self entry, a bare marker mid-graph, then an end marker.
    send_item(1'b0, 10'd1023, 10'd1023, 1'b0);
    send_item(1'b1, 10'd1021, 10'd1022, 1'b0);
    send_item(1'b1, 10'd1021, 10'd1023, 1'b0);
    send_item(1'b1, 10'd1022, 10'd1023, 1'b0);
    send_item(1'b1, 10'd1023, 10'd1023, 1'b0);
    send_item(1'b1, 10'd1023, 10'd1021, 1'b0);
    send_item(1'b0, 10'd1023, 10'd1023, 1'b1);
    // Sources out of order, so the in-lists end up unsorted.
    send_item(1'b1, 10'd2, 10'd4, 1'b0);
    send_item(1'b1, 10'd1, 10'd4, 1'b0);
    send_item(1'b1, 10'd1, 10'd2, 1'b0);
    send_item(1'b1, 10'd2, 10'd3, 1'b0);
    send_item(1'b1, 10'd1, 10'd3, 1'b0);
    send_item(1'b1, 10'd3, 10'd4, 1'b1);

    hub_graph(IN_DEGREE + 1);
    while (counted_items < TARGET_ITEMS) begin
      calm_phase = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 82) dense_graph();
      else if (pick < 86) hub_graph($urandom_range(IN_DEGREE - 2, IN_DEGREE + 6));
      else noise_burst();
    end
    calm_phase = 1'b0;
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("forward_triangle_counter verification clean");
    end else begin
      $display("forward_triangle_counter verification failed");
    end
    $finish;
  end

  initial begin : result_side
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        stall = pick_gap();
        m_tready <= (stall == 0);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("forward_triangle_counter verification failed");
    $finish;
  end

endmodule
